@@ rtl/endec_pkg.sv @@
// Shared types, character constants and the escape-code lookup for the escaped-name decoder.
// No dependencies; endec_step.sv and escaped_name_decoder.sv import it.
`default_nettype none

package endec_pkg;

  localparam int unsigned MaxResults = 4;
  localparam int unsigned CountW     = $clog2(MaxResults + 1);

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_UNDER = 8'h5F;

  // Pending bytes; zero marks an empty slot.
  typedef struct packed {
    logic [7:0] oldest;
    logic [7:0] middle;
    logic [7:0] newest;
  } window_t;

  // Words produced by one input byte, entry 0 goes out first.
  typedef struct packed {
    logic [CountW-1:0]               count;
    logic [MaxResults-1:0][7:0]      chars;
    logic [MaxResults-1:0]           eon;
  } burst_t;

  // Punctuation byte for a two-letter code, zero when the pair is no code.
  function automatic logic [7:0] code_lookup(input logic [7:0] x, input logic [7:0] y);
    logic [7:0] rep;
    unique case ({x, y})
      "sp":    rep = " ";
      "st":    rep = "*";
      "vb":    rep = "|";
      "lp":    rep = "(";
      "rp":    rep = ")";
      "lt":    rep = "<";
      "gt":    rep = ">";
      "am":    rep = "&";
      "at":    rep = "@";
      "eq":    rep = "=";
      "cm":    rep = ",";
      "sh":    rep = "#";
      "pl":    rep = "+";
      "do":    rep = "$";
      "pc":    rep = "%";
      "sq":    rep = "'";
      "sl":    rep = "/";
      "co":    rep = ":";
      "se":    rep = ";";
      "qu":    rep = "?";
      "dq":    rep = "\"";
      "bs":    rep = "\\";
      "us":    rep = "_";
      default: rep = CH_NUL;
    endcase
    return rep;
  endfunction

endpackage

`default_nettype wire

@@ rtl/endec_step.sv @@
// Combinational window update for one input byte: shift, rewrite rules, word list.
// Depends on endec_pkg.
`default_nettype none

module endec_step (
  input  var endec_pkg::window_t win,
  input  var logic [7:0]         sym,
  output endec_pkg::window_t     win_next,
  output endec_pkg::burst_t      res
);
  import endec_pkg::*;

  always_comb begin
    logic [7:0]        o;
    logic [7:0]        m;
    logic [7:0]        nw;
    logic [7:0]        rep;
    logic [CountW-1:0] n;

    n         = '0;
    res.chars = '0;
    res.eon   = '0;

    // oldest byte falls out of the window
    if (win.oldest != CH_NUL) begin
      res.chars[n[1:0]] = win.oldest;
      n = n + 1'b1;
    end

    o   = win.middle;
    m   = win.newest;
    nw  = sym;
    rep = code_lookup(m, nw);

    priority if (sym == CH_NUL) begin
      // terminator: flush what is left, then the end marker
      if (o != CH_NUL) begin
        res.chars[n[1:0]] = o;
        n = n + 1'b1;
      end
      if (m != CH_NUL) begin
        res.chars[n[1:0]] = m;
        n = n + 1'b1;
      end
      res.chars[n[1:0]] = CH_NUL;
      res.eon[n[1:0]]   = 1'b1;
      n  = n + 1'b1;
      o  = CH_NUL;
      m  = CH_NUL;
      nw = CH_NUL;
    end else if (m == CH_SLASH && nw == CH_UNDER) begin
      nw = CH_NUL;
    end else if (o == CH_UNDER && m == CH_UNDER) begin
      o = CH_NUL;
      m = CH_NUL;
    end else if (o == CH_UNDER && rep != CH_NUL) begin
      res.chars[n[1:0]] = rep;
      n  = n + 1'b1;
      o  = CH_NUL;
      m  = CH_NUL;
      nw = CH_NUL;
    end else begin
      // plain byte or unknown code: window stays as shifted
    end

    res.count       = n;
    win_next.oldest = o;
    win_next.middle = m;
    win_next.newest = nw;
  end

endmodule

`default_nettype wire

@@ rtl/escaped_name_decoder.sv @@
// Top level of the escaped-name decoder: input register, window, word burst buffer.
// Depends on endec_pkg and endec_step.
//
// Decodes a byte stream of escaped names, each ended by a zero byte. A three-byte
// window holds pending bytes; "_" followed by a two-letter code becomes a punctuation
// character, "__" and an underscore after "/" are dropped, and a zero byte flushes the
// window and sends a zero word flagged in tuser. Each input byte yields zero to four
// output words; the last word of a byte carries tlast, and a byte that yields none
// shows nothing on the output. Timing: a byte is taken into the input register and
// is decoded into the burst buffer once that is empty or the last word in it leaves;
// the output sends one word per cycle while m_tready is high, so the block sustains
// one byte per cycle while each byte yields at most one word; more words hold the
// next byte in the input register, the rate limit set by the single output port. The
// input register accepts a new byte while the buffer still drains the previous one.
`default_nettype none

module escaped_name_decoder (
  input  var logic       clk,
  input  var logic       rst,
  // input bytes
  input  var logic       s_tvalid,
  output logic           s_tready,
  input  var logic [7:0] s_tdata,   // [7:0] symbol
  // decoded words
  output logic           m_tvalid,
  input  var logic       m_tready,
  output logic [7:0]     m_tdata,   // [7:0] out_char
  output logic           m_tlast,   // last word caused by one input byte
  output logic           m_tuser    // [0] end_of_name
);
  import endec_pkg::*;

  logic       in_valid;
  logic [7:0] in_sym;

  window_t win;
  window_t win_next;
  burst_t  burst;
  burst_t  step_res;

  logic pop;
  logic in_moves;

  endec_step u_step (
    .win      (win),
    .sym      (in_sym),
    .win_next (win_next),
    .res      (step_res)
  );

  assign m_tvalid = (burst.count != '0);
  assign m_tdata  = burst.chars[0];
  assign m_tuser  = burst.eon[0];
  assign m_tlast  = (burst.count == CountW'(1));

  assign pop      = m_tvalid && m_tready;
  // the registered byte goes into the buffer once it is empty or its last word leaves
  assign in_moves = in_valid && (!m_tvalid || (pop && m_tlast));
  assign s_tready = !in_valid || in_moves;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_sym <= s_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win <= '0;
    end else if (in_moves) begin
      win <= win_next;
    end
  end

  // only the count needs a reset; words behind it are don't-care while empty
  always_ff @(posedge clk) begin
    if (rst) begin
      burst.count <= '0;
    end else if (in_moves) begin
      burst <= step_res;
    end else if (pop) begin
      burst.count <= burst.count - 1'b1;
      burst.chars <= burst.chars >> 8;
      burst.eon   <= burst.eon >> 1;
    end
  end

  // buffer never holds more than one byte's worth of words
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    burst.count <= CountW'(MaxResults))
    else $error("burst count above maximum");

  // the end marker is a zero word and always closes its byte's burst
  a_eon_word: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == CH_NUL && m_tlast)
    else $error("end marker malformed");

  // other words are never zero
  a_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata != CH_NUL)
    else $error("zero word without end marker");

  // a terminator leaves the window empty
  a_term_clears: assert property (@(posedge clk) disable iff (rst)
    in_moves && in_sym == CH_NUL |=> win == '0)
    else $error("window not cleared after terminator");

  // no input byte is lost: register holds while the buffer is busy
  a_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_moves |=> in_valid && $stable(in_sym))
    else $error("pending byte dropped");

endmodule

`default_nettype wire

@@ tb/tb_escaped_name_decoder.sv @@
// Self-checking testbench for escaped_name_decoder: random and directed byte streams.
// Predicts each output word with its own window model and compares in a scoreboard.
// Depends on endec_pkg and the escaped_name_decoder RTL.
`default_nettype none

module tb_escaped_name_decoder;
  import endec_pkg::*;

  // Two-letter escape codes, packed pairwise, and the character each one stands for.
  localparam string CodePairs = "spstvblprpltgtamateqcmshpldopcsqslcosequdqbsus";
  localparam string Puncts    = " *|()<>&@=,#+$%'/:;?\"\\_";
  localparam int    NumCodes  = 23;

  localparam int StallLimit = 400;  // cycles with no word moving on either side
  localparam int HoldCycles = 40;   // long output back-pressure stretch
  localparam int DrainWait  = 16;   // pipeline is two stages deep; margin on top

  // One expected output word.
  typedef struct {
    logic [7:0] ch;
    logic       last;
    logic       eon;
  } name_word_t;

  // Window model plus the queue of words still to come from the block.
  class NameDecodeBoard;
    window_t    win;
    name_word_t words_due[$];
    int         errors;

    function new();
      win    = '0;
      errors = 0;
    endfunction

    // Punctuation for a code pair, zero if the pair is no code.
    function logic [7:0] punct_for(logic [7:0] x, logic [7:0] y);
      logic [7:0] found;
      found = CH_NUL;
      for (int i = 0; i < NumCodes; i++) begin
        if (CodePairs[2*i] == x && CodePairs[2*i+1] == y) begin
          found = Puncts[i];
        end
      end
      return found;
    endfunction

    // An input byte was accepted: advance the window and queue its words.
    function void note_byte(logic [7:0] sym);
      name_word_t burst[$];
      logic [7:0] rep;
      if (win.oldest != CH_NUL) burst.push_back('{win.oldest, 1'b0, 1'b0});
      win = '{oldest: win.middle, middle: win.newest, newest: sym};
      if (sym == CH_NUL) begin
        // terminator: flush what is left, then the end-of-name zero
        if (win.oldest != CH_NUL) burst.push_back('{win.oldest, 1'b0, 1'b0});
        if (win.middle != CH_NUL) burst.push_back('{win.middle, 1'b0, 1'b0});
        burst.push_back('{CH_NUL, 1'b0, 1'b1});
        win = '0;
      end else if (win.middle == CH_SLASH && win.newest == CH_UNDER) begin
        win.newest = CH_NUL;
      end else if (win.oldest == CH_UNDER && win.middle == CH_UNDER) begin
        win.oldest = CH_NUL;
        win.middle = CH_NUL;
      end else if (win.oldest == CH_UNDER) begin
        rep = punct_for(win.middle, win.newest);
        if (rep != CH_NUL) begin
          win = '0;
          burst.push_back('{rep, 1'b0, 1'b0});
        end
      end
      if (burst.size() > 0) burst[burst.size()-1].last = 1'b1;
      foreach (burst[i]) words_due.push_back(burst[i]);
    endfunction

    // An output word was accepted: compare with the oldest expectation.
    function void check_word(logic [7:0] ch, logic last, logic eon);
      name_word_t due;
      if (words_due.size() == 0) begin
        $error("out_char: expected no word, got %02h", ch);
        errors++;
        return;
      end
      due = words_due.pop_front();
      if (ch !== due.ch) begin
        $error("out_char: expected %02h, got %02h", due.ch, ch);
        errors++;
      end
      if (last !== due.last) begin
        $error("last_of_run: expected %0b, got %0b", due.last, last);
        errors++;
      end
      if (eon !== due.eon) begin
        $error("end_of_name: expected %0b, got %0b", due.eon, eon);
        errors++;
      end
    endfunction

    function int pending();
      return words_due.size();
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst;
  logic       s_tvalid;
  logic       s_tready;
  logic [7:0] s_tdata;   // [7:0] symbol
  logic       m_tvalid;
  logic       m_tready;
  logic [7:0] m_tdata;   // [7:0] out_char
  logic       m_tlast;
  logic       m_tuser;   // [0] end_of_name

  NameDecodeBoard board;
  int sent;         // input bytes accepted so far
  int idle_pct;     // chance in percent that a side starts an idle burst; 0 = none
  int hold_left;    // remaining cycles of the long output hold
  logic hold_go;    // asks the receiver for the long hold, once
  logic hold_done;
  int quiet_cycles;

  escaped_name_decoder i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  always #4 clk = ~clk;

  // Offer one byte and wait for the handshake. Gaps are skipped during the
  // long hold so the input side keeps pushing while the output is blocked.
  task automatic send_byte(input logic [7:0] sym);
    int gap;
    gap = 0;
    if (hold_left == 0 && idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      gap = $urandom_range(1, 5);
    end
    repeat (gap) begin
      @(negedge clk);
      s_tvalid = 1'b0;
    end
    @(negedge clk);
    s_tvalid = 1'b1;
    s_tdata  = sym;
    do @(posedge clk); while (!s_tready);
    board.note_byte(sym);
    sent++;
  endtask

  // Text followed by the zero terminator.
  task automatic send_name(input string text);
    for (int i = 0; i < text.len(); i++) send_byte(text[i]);
    send_byte(CH_NUL);
  endtask

  // Mostly well-formed names built from escape pieces, with some noise mixed in.
  task automatic send_random_name();
    int pieces;
    int code;
    pieces = $urandom_range(0, 8);
    for (int p = 0; p < pieces; p++) begin
      code = $urandom_range(NumCodes - 1);
      case ($urandom_range(9))
        0, 1, 2: begin
          send_byte(CodePairs[$urandom_range(2*NumCodes - 1)]);
        end
        3, 4: begin  // known escape code
          send_byte(CH_UNDER);
          send_byte(CodePairs[2*code]);
          send_byte(CodePairs[2*code+1]);
        end
        5: begin  // doubled underscore
          send_byte(CH_UNDER);
          send_byte(CH_UNDER);
        end
        6: begin  // underscore after slash
          send_byte(CH_SLASH);
          send_byte(CH_UNDER);
        end
        7: begin  // underscore with a mostly unknown pair
          send_byte(CH_UNDER);
          send_byte(8'(8'h61 + $urandom_range(25)));
          send_byte(8'(8'h61 + $urandom_range(25)));
        end
        default: begin
          send_byte(8'($urandom_range(1, 255)));
        end
      endcase
    end
    send_byte(CH_NUL);
  endtask

  // Output side: random stall bursts, plus the one long hold on request.
  initial begin : receiver
    int stall_left;
    stall_left = 0;
    hold_left  = 0;
    hold_done  = 1'b0;
    m_tready   = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_go && !hold_done) begin
        hold_left = HoldCycles;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_tready = 1'b0;
      end else if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
        stall_left = $urandom_range(1, 5) - 1;
        m_tready = 1'b0;
      end else begin
        m_tready = 1'b1;
      end
    end
  end

  // Check accepted words and watch for a stuck handshake.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) board.check_word(m_tdata, m_tlast, m_tuser);
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles == StallLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    board        = new();
    rst          = 1'b1;
    s_tvalid     = 1'b0;
    s_tdata      = 8'h00;
    sent         = 0;
    idle_pct     = 0;
    hold_go      = 1'b0;
    quiet_cycles = 0;
    repeat (6) @(negedge clk);
    rst = 1'b0;

    // directed: empty name, extreme bytes, each rewrite rule, unknown code
    idle_pct = 25;
    send_byte(CH_NUL);
    send_byte(8'hFF);
    send_byte(8'h01);
    send_byte(8'h80);
    send_byte(CH_NUL);
    send_name("/_a");
    send_name("a__b");
    send_name("_sp");
    send_name("_zz");

    // random names, idling level changes per name; long hold once midway
    while (sent < 230) begin
      case ($urandom_range(2))
        0:       idle_pct = 0;
        1:       idle_pct = 20;
        default: idle_pct = 50;
      endcase
      if (sent >= 120) hold_go = 1'b1;
      send_random_name();
    end

    // full-rate tail
    idle_pct = 0;
    while (sent < 270) send_random_name();
    @(negedge clk);
    s_tvalid = 1'b0;

    while (board.pending() != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ files.f @@
rtl/endec_pkg.sv
rtl/endec_step.sv
rtl/escaped_name_decoder.sv
tb/tb_escaped_name_decoder.sv
